>>> hw/rtl/ktr_pkg.sv
// ktr_pkg: shared types, constants and compare helpers for the k-smallest tracker
// depends on nothing; imported by the controller, datapath and top level
`timescale 1ns / 1ps

package ktr_pkg;

    localparam int MAX_KEEP = 16;
    localparam int IDX_W    = $clog2(MAX_KEEP);
    localparam int CNT_W    = $clog2(MAX_KEEP + 1);
    localparam int VAL_W    = 64;
    localparam int POS_W    = 16;
    localparam int DATA_W   = VAL_W + 2 * POS_W;
    localparam int CFG_W    = 6;

    localparam logic [1:0] FMT_UINT = 2'd0;
    localparam logic [1:0] FMT_SINT = 2'd1;
    localparam logic [1:0] FMT_F32  = 2'd2;
    localparam logic [1:0] FMT_F64  = 2'd3;

    localparam logic [1:0] REG_KEEP   = 2'd0;
    localparam logic [1:0] REG_FORMAT = 2'd1;
    localparam logic [1:0] REG_INTB   = 2'd2;

    localparam logic [VAL_W-1:0] SIGN64 = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_SCAN, ST_INSERT, ST_STOPCHK, ST_FINISH, ST_EMIT
    } ktr_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic idx_clr;
        logic idx_inc;
        logic insert;
        logic stop_chk;
        logic clear_list;
    } ktr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic stopped;
        logic usable;
        logic last;
        logic full;
        logic scan_done;
        logic lt_head;
        logic emit_last;
    } ktr_stat_t;

    typedef struct packed {
        logic lt;
        logic ge;
    } ktr_cmp_t;

    function automatic logic is_nan(input logic [VAL_W-1:0] b, input logic [1:0] fmt);
        logic r;
        if (fmt == FMT_F32) r = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        else                r = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        return r;
    endfunction

    // order-preserving key, both zeros map to the same key
    function automatic logic [VAL_W-1:0] fkey(input logic [VAL_W-1:0] b, input logic [1:0] fmt);
        logic [VAL_W-1:0] k;
        if (fmt == FMT_F32) begin
            if (b[30:0] == 31'd0)  k = {32'd0, 32'h8000_0000};
            else if (b[31])        k = {32'd0, ~b[31:0]};
            else                   k = {32'd0, b[31:0] | 32'h8000_0000};
        end else begin
            if (b[62:0] == 63'd0)  k = SIGN64;
            else if (b[63])        k = ~b;
            else                   k = b | SIGN64;
        end
        return k;
    endfunction

    function automatic ktr_cmp_t val_cmp(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                                         input logic [1:0] fmt);
        ktr_cmp_t r;
        case (fmt)
            FMT_UINT: r.lt = a < b;
            FMT_SINT: r.lt = (a ^ SIGN64) < (b ^ SIGN64);
            default:  r.lt = fkey(a, fmt) < fkey(b, fmt);
        endcase
        r.ge = !r.lt;
        if ((fmt == FMT_F32 || fmt == FMT_F64) && (is_nan(a, fmt) || is_nan(b, fmt))) begin
            r.lt = 1'b0;
            r.ge = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/k_smallest_tracker_top.sv
// k_smallest_tracker_top: streaming tracker of the keep_count smallest values
// depends on ktr_pkg, ktr_ctrl and ktr_datapath
//
// channel  direction  contents
// s_       in         tdata: sample_value, x_pos, y_pos; tlast: last_element
// m_       out        tdata: kept_value, kept_x, kept_y; tuser: entry_valid; tlast: last_result
// cfg_     in         write enable, register index, write data
//
// an element is skipped after its check, or goes through a scan, an insert and, when it
// displaces the largest entry of a full list, an early stop check:
// the list is scanned one entry a cycle through a single shared comparator
// on the last element the result beats are sent in turn, each held until m_tready
// no element is taken while results are being sent
// reset is synchronous, active low; it empties the list and restores the registers
`timescale 1ns / 1ps

module k_smallest_tracker_top
    import ktr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // sample_value[63:0], x_pos[79:64], y_pos[95:80]
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // kept_value[63:0], kept_x[79:64], kept_y[95:80]
    output logic              m_tuser,   // entry_valid[0]
    output logic              m_tlast
);

    ktr_cmd_t  cmd;
    ktr_stat_t stat;

    // sequencer
    ktr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // list and compare
    ktr_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> hw/rtl/ktr_ctrl.sv
// ktr_ctrl: sequencer for load, scan, insert, early stop check and emission
// depends on ktr_pkg
`timescale 1ns / 1ps

module ktr_ctrl
    import ktr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  ktr_stat_t stat,
    output ktr_cmd_t  cmd
);

    ktr_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.idx_clr = 1'b1;
                if (stat.stopped || !stat.usable)     state_next = ST_FINISH;
                else if (!stat.full || stat.lt_head)  state_next = ST_SCAN;
                else                                  state_next = ST_FINISH;
            end
            ST_SCAN: begin
                if (stat.scan_done) state_next = ST_INSERT;
                else                cmd.idx_inc = 1'b1;
            end
            ST_INSERT: begin
                cmd.insert  = 1'b1;
                cmd.idx_clr = 1'b1;
                state_next  = stat.full ? ST_STOPCHK : ST_FINISH;
            end
            ST_STOPCHK: begin
                cmd.stop_chk = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.idx_clr = 1'b1;
                state_next  = stat.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (stat.emit_last) begin
                        cmd.clear_list = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/ktr_datapath.sv
// ktr_datapath: config registers, sorted list, shared comparator and output mux
// depends on ktr_pkg
`timescale 1ns / 1ps

module ktr_datapath
    import ktr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  ktr_cmd_t          cmd,
    output ktr_stat_t         stat,
    output logic [DATA_W-1:0] m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    logic [4:0]       keep_reg;
    logic [1:0]       fmt_reg;
    logic [5:0]       intb_reg;
    logic [VAL_W-1:0] v_reg;
    logic [POS_W-1:0] x_reg, y_reg;
    logic             last_reg;
    logic [CNT_W-1:0] fill_reg, idx_reg;
    logic             stop_reg;
    logic [VAL_W-1:0] lv_reg [MAX_KEEP];
    logic [POS_W-1:0] lx_reg [MAX_KEEP];
    logic [POS_W-1:0] ly_reg [MAX_KEEP];

    logic [CNT_W-1:0] keff;
    logic [5:0]       bsat;
    logic [VAL_W-1:0] lowest, cmp_a, rd_v, in_v;
    logic [IDX_W-1:0] rd_idx;
    ktr_cmp_t         cmp;
    logic             is_float;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg <= 5'd1;
            fmt_reg  <= FMT_UINT;
            intb_reg <= 6'd8;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_KEEP:   keep_reg <= cfg_wdata[4:0];
                REG_FORMAT: fmt_reg  <= cfg_wdata[1:0];
                REG_INTB:   intb_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // effective keep count and lowest integer value
    always_comb begin
        if (keep_reg == 5'd0)                       keff = CNT_W'(1);
        else if (32'(keep_reg) > 32'(MAX_KEEP))     keff = CNT_W'(MAX_KEEP);
        else                                        keff = CNT_W'(keep_reg);
        if (intb_reg < 6'd8)       bsat = 6'd8;
        else if (intb_reg > 6'd32) bsat = 6'd32;
        else                       bsat = intb_reg;
        if (fmt_reg == FMT_UINT) lowest = '0;
        else                     lowest = VAL_W'(0) - (VAL_W'(1) << (bsat - 6'd1));
    end

    assign is_float = (fmt_reg == FMT_F32) || (fmt_reg == FMT_F64);
    assign in_v     = (fmt_reg == FMT_F32) ? {32'd0, s_tdata[31:0]} : s_tdata[VAL_W-1:0];
    assign rd_idx   = idx_reg[IDX_W-1:0];
    assign rd_v     = lv_reg[rd_idx];
    assign cmp_a    = cmd.stop_chk ? lowest : v_reg;
    assign cmp      = val_cmp(cmp_a, rd_v, fmt_reg);

    // status towards the controller
    always_comb begin
        stat.stopped   = stop_reg;
        stat.usable    = !(is_float && is_nan(v_reg, fmt_reg));
        stat.last      = last_reg;
        stat.full      = fill_reg >= keff;
        stat.scan_done = (idx_reg >= fill_reg) || cmp.ge;
        stat.lt_head   = cmp.lt;
        stat.emit_last = (fill_reg == '0) || (idx_reg + CNT_W'(1) == fill_reg);
    end

    // item beat, index counter, fill and stop flag
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v_reg    <= in_v;
            x_reg    <= s_tdata[VAL_W +: POS_W];
            y_reg    <= s_tdata[VAL_W+POS_W +: POS_W];
            last_reg <= s_tlast;
        end
        if (!aresetn) begin
            fill_reg <= '0;
            stop_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            if (cmd.idx_clr)      idx_reg <= '0;
            else if (cmd.idx_inc) idx_reg <= idx_reg + CNT_W'(1);
            if (cmd.insert && !stat.full) fill_reg <= fill_reg + CNT_W'(1);
            if (cmd.stop_chk && !is_float && !cmp.lt) stop_reg <= 1'b1;
            if (cmd.clear_list) begin
                fill_reg <= '0;
                stop_reg <= 1'b0;
            end
        end
    end

    // list shift and insert, position given by the index counter
    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            for (int j = 0; j < MAX_KEEP; j++) begin
                if (stat.full) begin
                    if (j + 1 < MAX_KEEP && CNT_W'(j + 1) < idx_reg) begin
                        lv_reg[j] <= lv_reg[j+1];
                        lx_reg[j] <= lx_reg[j+1];
                        ly_reg[j] <= ly_reg[j+1];
                    end else if (CNT_W'(j + 1) == idx_reg) begin
                        lv_reg[j] <= v_reg;
                        lx_reg[j] <= x_reg;
                        ly_reg[j] <= y_reg;
                    end
                end else begin
                    if (j > 0 && CNT_W'(j) > idx_reg && CNT_W'(j) <= fill_reg) begin
                        lv_reg[j] <= lv_reg[j-1];
                        lx_reg[j] <= lx_reg[j-1];
                        ly_reg[j] <= ly_reg[j-1];
                    end else if (CNT_W'(j) == idx_reg) begin
                        lv_reg[j] <= v_reg;
                        lx_reg[j] <= x_reg;
                        ly_reg[j] <= y_reg;
                    end
                end
            end
        end
    end

    // result beat
    always_comb begin
        if (fill_reg == '0) begin
            m_tdata = '0;
            m_tuser = 1'b0;
        end else begin
            m_tdata = {ly_reg[rd_idx], lx_reg[rd_idx], rd_v};
            m_tuser = 1'b1;
        end
        m_tlast = stat.emit_last;
    end

endmodule
